// ===== src/kmc_pkg.sv =====
// Package for the 2-D k-means clustering unit: fixed field widths, codes,
// channel word types and the sequencer state type.
// No dependencies; compiled first.
package kmc_pkg;

  localparam int CENT_W = 24;
  localparam int CNT_OUT_W = 13;
  localparam int PASS_W = 8;
  localparam logic [PASS_W-1:0] MAX_PASS_RST = 8'd10;
  localparam logic signed [CENT_W-1:0] CENT_MAX = 24'sh7FFFFF;
  localparam logic signed [CENT_W-1:0] CENT_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_SET_CENT = 3'd1,
    OP_RUN      = 3'd2,
    OP_READ     = 3'd3,
    OP_CLEAR    = 3'd4
  } kmc_op_t;

  typedef enum logic [1:0] {
    RS_CONVERGED  = 2'd0,
    RS_MAX_PASSES = 2'd1,
    RS_EMPTY      = 2'd2,
    RS_NO_POINTS  = 2'd3
  } kmc_status_t;

  typedef enum logic {
    KIND_CENTROID = 1'b0,
    KIND_ASSIGN   = 1'b1
  } kmc_kind_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [11:0]        item_index;
    logic signed [23:0] centroid_x;
    logic signed [23:0] centroid_y;
  } kmc_in_word_t;

  typedef struct packed {
    logic               report_kind;
    logic [2:0]         cluster_number;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic [12:0]        member_count;
    logic [7:0]         passes_done;
    logic [1:0]         run_status;
    logic               last_result;
  } kmc_out_word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PSTART,
    S_PREAD,
    S_PLOAD,
    S_DX,
    S_SQX,
    S_SQY,
    S_CMP,
    S_ACC,
    S_ECHK,
    S_DIV_LD,
    S_DIV,
    S_DIV_END,
    S_PEND,
    S_REP,
    S_RD,
    S_RDOUT
  } kmc_state_t;

endpackage

// ===== src/kmc_if.sv =====
// Channel interfaces of the k-means clustering unit: input, result and
// configuration words with valid/ready. Depends on kmc_pkg.
interface kmc_in_if import kmc_pkg::*; ();
  logic         valid;
  logic         ready;
  kmc_in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmc_out_if import kmc_pkg::*; ();
  logic          valid;
  logic          ready;
  kmc_out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmc_cfg_if import kmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PASS_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/kmc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module kmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read first (old data on a same-address write), read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/kmeans_2d_clustering_unit.sv =====
// Top level of the 2-D k-means (Lloyd) clustering unit.
// Depends on kmc_pkg, the interfaces in kmc_if and the RAM in kmc_ram.
//
//   channel  dir  handshake            word
//   in_ch    in   in_ch.valid/ready    op, point, index, centroid
//   out_ch   out  out_ch.valid/ready   centroid report or assignment report
//   cfg_ch   in   cfg_ch.valid/ready   most passes per run (8 bits)
//
// Load, set centroid and clear complete in the idle state. A read goes through S_RD and S_RDOUT.
// A run over N points and K clusters uses one shared abs-difference unit and
// one squarer that go over every point and cluster, and one bit-serial divider
// that forms each mean coordinate as an NW-bit quotient, NW = sum width plus
// FRAC_BITS.
// Reset is synchronous, active low; no clearing pass is needed.
// in_ch is ready only while the sequencer is idle; a report waits in the
// output register while out_ch stalls.
module kmeans_2d_clustering_unit import kmc_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int CLUSTERS   = 4,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input logic        clk,
  input logic        rst_n,
  kmc_in_if.sink     in_ch,
  kmc_out_if.source  out_ch,
  kmc_cfg_if.sink    cfg_ch
);

  localparam int PB   = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int KW   = $clog2(CLUSTERS);
  localparam int SPW  = PB + FRAC_BITS;
  localparam int DW   = ((SPW > CENT_W) ? SPW : CENT_W) + 1;
  localparam int SW   = PB + CW;
  localparam int NW   = SW + FRAC_BITS;
  localparam int QW   = ((NW + 1) > (CENT_W + 1)) ? (NW + 1) : (CENT_W + 1);
  localparam int DCW  = $clog2(NW + 1);

  // Registers.
  kmc_state_t               state_r, state_nxt;
  logic [PASS_W-1:0]        max_pass_r, max_pass_nxt;
  logic [CW-1:0]            points_loaded_r, points_loaded_nxt;
  logic [CW-1:0]            assigned_cnt_r, assigned_cnt_nxt;
  logic [PASS_W-1:0]        pass_cnt_r, pass_cnt_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [KW-1:0]            k_r, k_nxt;
  logic [KW-1:0]            bk_r, bk_nxt;
  logic [AW-1:0]            pt_idx_r, pt_idx_nxt;
  logic [AW-1:0]            rd_addr_r, rd_addr_nxt;
  logic                     rd_hit_r, rd_hit_nxt;
  logic signed [PB-1:0]     px_r, px_nxt, py_r, py_nxt;
  logic [DW-1:0]            dabs_r, dabs_nxt;
  logic [2*DW-1:0]          sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [2*DW:0]            best_r, best_nxt;
  logic                     changed_r, changed_nxt;
  logic                     dsel_y_r, dsel_y_nxt;
  logic                     neg_r, neg_nxt;
  logic [NW-1:0]            quo_r, quo_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic [DCW-1:0]           dcnt_r, dcnt_nxt;
  logic signed [CENT_W-1:0] nx_r, nx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  kmc_out_word_t            out_word_r, out_word_nxt;
  logic signed [CENT_W-1:0] cx_r [CLUSTERS];
  logic signed [CENT_W-1:0] cx_nxt [CLUSTERS];
  logic signed [CENT_W-1:0] cy_r [CLUSTERS];
  logic signed [CENT_W-1:0] cy_nxt [CLUSTERS];
  logic signed [SW-1:0]     sum_x_r [CLUSTERS];
  logic signed [SW-1:0]     sum_x_nxt [CLUSTERS];
  logic signed [SW-1:0]     sum_y_r [CLUSTERS];
  logic signed [SW-1:0]     sum_y_nxt [CLUSTERS];
  logic [CW-1:0]            cnt_r [CLUSTERS];
  logic [CW-1:0]            cnt_nxt [CLUSTERS];

  // Memory ports.
  logic                     pt_we;
  logic [2*PB-1:0]          pt_rdata;
  logic                     as_we;
  logic [KW-1:0]            as_rdata;

  // Combinational helpers.
  kmc_in_word_t             in_w;
  logic                     in_acc;
  logic                     out_free;
  logic [KW-1:0]            rd_k;
  logic signed [SW-1:0]     sum_x_rd, sum_y_rd, sum_sel;
  logic [CW-1:0]            cnt_rd;
  logic signed [SPW-1:0]    pxs, pys, ad_a;
  logic signed [CENT_W-1:0] ad_b;
  logic signed [DW-1:0]     diff;
  logic [DW-1:0]            diff_abs;
  logic [2*DW-1:0]          sq;
  logic [2*DW:0]            dist_sum;
  logic [SW-1:0]            sum_abs;
  logic [CW:0]              rem_sh;
  logic                     rem_ge;
  logic signed [QW-1:0]     qv;
  logic signed [CENT_W-1:0] qsat;
  logic                     any_empty;
  logic [PASS_W-1:0]        limit;
  logic                     last_pt;

  assign in_w         = in_ch.data;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Point store: y in the upper half, x in the lower half.
  kmc_ram #(.WIDTH(2 * PB), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (points_loaded_r[AW-1:0]),
    .wdata ({in_w.point_y[PB-1:0], in_w.point_x[PB-1:0]}),
    .raddr (pt_idx_r),
    .rdata (pt_rdata)
  );

  // Assignment store; entries at or above assigned_cnt_r read as cluster 0.
  kmc_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_assign_ram (
    .clk   (clk),
    .we    (as_we),
    .waddr (pt_idx_r),
    .wdata (bk_r),
    .raddr (rd_addr_r),
    .rdata (as_rdata)
  );

  // Single indexed read port on the per-cluster sums and counts; the empty check reads all counts.
  assign rd_k     = (state_r == S_ACC) ? bk_r : k_r;
  assign sum_x_rd = sum_x_r[rd_k];
  assign sum_y_rd = sum_y_r[rd_k];
  assign cnt_rd   = cnt_r[rd_k];

  // Shared abs-difference unit and squarer.
  assign pxs      = SPW'(px_r) <<< FRAC_BITS;
  assign pys      = SPW'(py_r) <<< FRAC_BITS;
  assign ad_a     = (state_r == S_SQX) ? pys : pxs;
  assign ad_b     = (state_r == S_SQX) ? cy_r[k_r] : cx_r[k_r];
  assign diff     = DW'(ad_a) - DW'(ad_b);
  assign diff_abs = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign sq       = dabs_r * dabs_r;
  assign dist_sum = (2*DW+1)'(sqx_r) + (2*DW+1)'(sqy_r);

  // Divider operand and one restoring step.
  assign sum_sel = dsel_y_r ? sum_y_rd : sum_x_rd;
  assign sum_abs = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign rem_ge  = rem_sh >= {1'b0, cnt_rd};

  // Signed quotient saturated to the centroid range.
  assign qv = neg_r ? -QW'(quo_r) : QW'(quo_r);
  always_comb begin
    if ((&qv[QW-1:CENT_W-1]) || !(|qv[QW-1:CENT_W-1])) begin
      qsat = qv[CENT_W-1:0];
    end else begin
      qsat = qv[QW-1] ? CENT_MIN : CENT_MAX;
    end
  end

  always_comb begin
    any_empty = 1'b0;
    for (int k = 0; k < CLUSTERS; k++) begin
      if (cnt_r[k] == '0) begin
        any_empty = 1'b1;
      end
    end
  end

  assign limit   = (max_pass_r == '0) ? PASS_W'(1) : max_pass_r;
  assign last_pt = (CW'(pt_idx_r) + CW'(1)) == points_loaded_r;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt         = state_r;
    max_pass_nxt      = max_pass_r;
    points_loaded_nxt = points_loaded_r;
    assigned_cnt_nxt  = assigned_cnt_r;
    pass_cnt_nxt      = pass_cnt_r;
    status_nxt        = status_r;
    k_nxt             = k_r;
    bk_nxt            = bk_r;
    pt_idx_nxt        = pt_idx_r;
    rd_addr_nxt       = rd_addr_r;
    rd_hit_nxt        = rd_hit_r;
    px_nxt            = px_r;
    py_nxt            = py_r;
    dabs_nxt          = dabs_r;
    sqx_nxt           = sqx_r;
    sqy_nxt           = sqy_r;
    best_nxt          = best_r;
    changed_nxt       = changed_r;
    dsel_y_nxt        = dsel_y_r;
    neg_nxt           = neg_r;
    quo_nxt           = quo_r;
    rem_nxt           = rem_r;
    dcnt_nxt          = dcnt_r;
    nx_nxt            = nx_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_word_nxt      = out_word_r;
    cx_nxt            = cx_r;
    cy_nxt            = cy_r;
    sum_x_nxt         = sum_x_r;
    sum_y_nxt         = sum_y_r;
    cnt_nxt           = cnt_r;
    pt_we             = 1'b0;
    as_we             = 1'b0;

    if (cfg_ch.valid && cfg_ch.ready) begin
      max_pass_nxt = cfg_ch.data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_w.op)
            OP_LOAD: begin
              if (points_loaded_r < CW'(MAX_POINTS)) begin
                pt_we             = 1'b1;
                points_loaded_nxt = points_loaded_r + CW'(1);
              end
            end
            OP_SET_CENT: begin
              if (32'(in_w.item_index) < 32'(CLUSTERS)) begin
                cx_nxt[KW'(in_w.item_index)] = in_w.centroid_x;
                cy_nxt[KW'(in_w.item_index)] = in_w.centroid_y;
              end
            end
            OP_RUN: begin
              pass_cnt_nxt = '0;
              k_nxt        = '0;
              if (points_loaded_r == '0) begin
                status_nxt = RS_NO_POINTS;
                for (int k = 0; k < CLUSTERS; k++) begin
                  cnt_nxt[k] = '0;
                end
                state_nxt = S_REP;
              end else begin
                state_nxt = S_PSTART;
              end
            end
            OP_READ: begin
              rd_addr_nxt = AW'(32'(in_w.item_index));
              rd_hit_nxt  = 32'(in_w.item_index) < 32'(assigned_cnt_r);
              state_nxt   = S_RD;
            end
            OP_CLEAR: begin
              points_loaded_nxt = '0;
              assigned_cnt_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Start of a Lloyd pass: count the pass and clear the accumulators.
      S_PSTART: begin
        pass_cnt_nxt = pass_cnt_r + PASS_W'(1);
        changed_nxt  = 1'b0;
        pt_idx_nxt   = '0;
        for (int k = 0; k < CLUSTERS; k++) begin
          sum_x_nxt[k] = '0;
          sum_y_nxt[k] = '0;
          cnt_nxt[k]   = '0;
        end
        state_nxt = S_PREAD;
      end

      S_PREAD: begin
        state_nxt = S_PLOAD;
      end

      S_PLOAD: begin
        px_nxt    = pt_rdata[PB-1:0];
        py_nxt    = pt_rdata[2*PB-1:PB];
        k_nxt     = '0;
        state_nxt = S_DX;
      end

      // Distance to cluster k_r: |dx|, dx^2 with |dy|, dy^2, then compare.
      S_DX: begin
        dabs_nxt  = diff_abs;
        state_nxt = S_SQX;
      end

      S_SQX: begin
        sqx_nxt   = sq;
        dabs_nxt  = diff_abs;
        state_nxt = S_SQY;
      end

      S_SQY: begin
        sqy_nxt   = sq;
        state_nxt = S_CMP;
      end

      // Strict less-than keeps the lowest cluster on a tie.
      S_CMP: begin
        if (k_r == '0 || dist_sum < best_r) begin
          best_nxt = dist_sum;
          bk_nxt   = k_r;
        end
        if (k_r == KW'(CLUSTERS - 1)) begin
          state_nxt = S_ACC;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_DX;
        end
      end

      // Record the assignment and add the point to its cluster.
      S_ACC: begin
        as_we            = 1'b1;
        sum_x_nxt[bk_r]  = sum_x_rd + SW'(px_r);
        sum_y_nxt[bk_r]  = sum_y_rd + SW'(py_r);
        cnt_nxt[bk_r]    = cnt_rd + CW'(1);
        if (last_pt) begin
          assigned_cnt_nxt = points_loaded_r;
          state_nxt        = S_ECHK;
        end else begin
          pt_idx_nxt = pt_idx_r + AW'(1);
          state_nxt  = S_PREAD;
        end
      end

      S_ECHK: begin
        k_nxt = '0;
        if (any_empty) begin
          status_nxt = RS_EMPTY;
          state_nxt  = S_REP;
        end else begin
          dsel_y_nxt = 1'b0;
          state_nxt  = S_DIV_LD;
        end
      end

      // Mean of one coordinate: |sum| * 2^FRAC_BITS / count, bit-serial.
      S_DIV_LD: begin
        neg_nxt   = sum_sel[SW-1];
        quo_nxt   = NW'(sum_abs) << FRAC_BITS;
        rem_nxt   = '0;
        dcnt_nxt  = DCW'(NW);
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (rem_ge) begin
          rem_nxt = CW'(rem_sh - {1'b0, cnt_rd});
        end else begin
          rem_nxt = rem_sh[CW-1:0];
        end
        quo_nxt  = {quo_r[NW-2:0], rem_ge};
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) begin
          state_nxt = S_DIV_END;
        end
      end

      S_DIV_END: begin
        if (!dsel_y_r) begin
          nx_nxt     = qsat;
          dsel_y_nxt = 1'b1;
          state_nxt  = S_DIV_LD;
        end else begin
          if (nx_r != cx_r[k_r] || qsat != cy_r[k_r]) begin
            changed_nxt = 1'b1;
          end
          cx_nxt[k_r] = nx_r;
          cy_nxt[k_r] = qsat;
          dsel_y_nxt  = 1'b0;
          if (k_r == KW'(CLUSTERS - 1)) begin
            state_nxt = S_PEND;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = S_DIV_LD;
          end
        end
      end

      S_PEND: begin
        k_nxt = '0;
        if (!changed_r) begin
          status_nxt = RS_CONVERGED;
          state_nxt  = S_REP;
        end else if (pass_cnt_r >= limit) begin
          status_nxt = RS_MAX_PASSES;
          state_nxt  = S_REP;
        end else begin
          state_nxt = S_PSTART;
        end
      end

      // One centroid word per cluster, in cluster order.
      S_REP: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.report_kind    = KIND_CENTROID;
          out_word_nxt.cluster_number = 3'(k_r);
          out_word_nxt.mean_x         = cx_r[k_r];
          out_word_nxt.mean_y         = cy_r[k_r];
          out_word_nxt.member_count   = CNT_OUT_W'(cnt_rd);
          out_word_nxt.passes_done    = pass_cnt_r;
          out_word_nxt.run_status     = status_r;
          out_word_nxt.last_result    = (k_r == KW'(CLUSTERS - 1));
          if (k_r == KW'(CLUSTERS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end

      S_RD: begin
        state_nxt = S_RDOUT;
      end

      S_RDOUT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.report_kind    = KIND_ASSIGN;
          out_word_nxt.cluster_number = rd_hit_r ? 3'(as_rdata) : 3'd0;
          out_word_nxt.mean_x         = '0;
          out_word_nxt.mean_y         = '0;
          out_word_nxt.member_count   = '0;
          out_word_nxt.passes_done    = '0;
          out_word_nxt.run_status     = RS_CONVERGED;
          out_word_nxt.last_result    = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      max_pass_r      <= MAX_PASS_RST;
      points_loaded_r <= '0;
      assigned_cnt_r  <= '0;
      pass_cnt_r      <= '0;
      out_valid_r     <= 1'b0;
      for (int k = 0; k < CLUSTERS; k++) begin
        cx_r[k]  <= '0;
        cy_r[k]  <= '0;
        cnt_r[k] <= '0;
      end
    end else begin
      state_r         <= state_nxt;
      max_pass_r      <= max_pass_nxt;
      points_loaded_r <= points_loaded_nxt;
      assigned_cnt_r  <= assigned_cnt_nxt;
      pass_cnt_r      <= pass_cnt_nxt;
      out_valid_r     <= out_valid_nxt;
      cx_r            <= cx_nxt;
      cy_r            <= cy_nxt;
      cnt_r           <= cnt_nxt;
    end
    status_r   <= status_nxt;
    k_r        <= k_nxt;
    bk_r       <= bk_nxt;
    pt_idx_r   <= pt_idx_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rd_hit_r   <= rd_hit_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    dabs_r     <= dabs_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    best_r     <= best_nxt;
    changed_r  <= changed_nxt;
    dsel_y_r   <= dsel_y_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    nx_r       <= nx_nxt;
    out_word_r <= out_word_nxt;
    sum_x_r    <= sum_x_nxt;
    sum_y_r    <= sum_y_nxt;
  end

  // Checks on the sequencer's own bookkeeping.
  a_loaded_max: assert property (@(posedge clk) disable iff (!rst_n)
    points_loaded_r <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_assigned_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    assigned_cnt_r <= points_loaded_r)
    else $error("assignments recorded beyond loaded points");

  a_point_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DX) |-> (CW'(pt_idx_r) < points_loaded_r))
    else $error("pass reads a point that is not loaded");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_LD) |-> (cnt_rd != '0))
    else $error("mean division by an empty cluster");

  a_last_centroid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.data.last_result &&
     out_ch.data.report_kind == KIND_CENTROID)
    |-> (out_ch.data.cluster_number == 3'(CLUSTERS - 1)))
    else $error("run report ended before the last cluster");

endmodule
